// ----- sv/msm_pkg.sv -----
// package for the multi-stack shared memory block
// holds default sizes, field widths, request and status codes
// no dependencies
package msm_pkg;

    localparam int CAPACITY_DEF    = 32;
    localparam int STACK_COUNT_DEF = 4;

    localparam int REQ_W    = 2;
    localparam int SEL_W    = 4;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd3;

endpackage

// ----- sv/msm_if.sv -----
// request and response channel interfaces for the multi-stack block
// depends on msm_pkg for field widths
interface msm_req_if;
    logic                                 valid;
    logic                                 ready;
    logic        [msm_pkg::REQ_W-1:0]     req_type;
    logic        [msm_pkg::SEL_W-1:0]     stack_select;
    logic signed [msm_pkg::DATA_W-1:0]    push_value;

    modport source (output valid, req_type, stack_select, push_value, input ready);
    modport sink   (input valid, req_type, stack_select, push_value, output ready);
endinterface

interface msm_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic        [msm_pkg::STATUS_W-1:0]  status;
    logic signed [msm_pkg::DATA_W-1:0]    read_value;
    logic                                 now_empty;
    logic                                 now_full;

    modport source (output valid, status, read_value, now_empty, now_full, input ready);
    modport sink   (input valid, status, read_value, now_empty, now_full, output ready);
endinterface

// ----- sv/msm_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module msm_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] ram_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= ram_mem[rd_addr];
        end
    end

endmodule

// ----- sv/multi_stack_shared_memory.sv -----
// top level of the multi-stack shared memory block
// depends on msm_pkg, msm_req_if / msm_rsp_if and msm_ram
//
//   channel   dir   payload                                       handshake
//   req       in    req_type, stack_select, push_value            valid / ready
//   rsp       out   status, read_value, now_empty, now_full       valid / ready
//
// one response transaction per request transaction, in order
// a request passes accept (count lookup, ram write or read issue), then stage b,
// which waits on ram read data; no new request is taken while one is in stage b
// a new request is taken in the same cycle that the last response leaves
// reset clears stack counts and valid flags at once; no clearing pass is needed
// stalls on rsp hold the response register and keep req closed until it is taken
module multi_stack_shared_memory #(
    parameter int CAPACITY    = msm_pkg::CAPACITY_DEF,
    parameter int STACK_COUNT = msm_pkg::STACK_COUNT_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    msm_req_if.sink   req,
    msm_rsp_if.source rsp
);

    // segment size and derived widths
    localparam int SEG = CAPACITY / STACK_COUNT;
    localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = (SEG > 0) ? $clog2(SEG + 1) : 1;
    localparam int SW  = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;
    localparam int NC  = 2 ** SW;

    // per-stack fill counts, cleared by reset
    logic [CW-1:0] counts_reg [NC];
    logic [CW-1:0] cnt_next;

    // stage after accept, waiting on ram read data
    logic                          b_valid_reg;
    logic [msm_pkg::STATUS_W-1:0]  b_status_reg;
    logic                          b_rd_take_reg;
    logic                          b_empty_reg;
    logic                          b_full_reg;

    // response register
    logic                          out_valid_reg;
    logic [msm_pkg::STATUS_W-1:0]  out_status_reg;
    logic [msm_pkg::DATA_W-1:0]    out_value_reg;
    logic                          out_empty_reg;
    logic                          out_full_reg;

    logic                          req_acc;
    logic                          sel_ok;
    logic [SW-1:0]                 sel_idx;
    logic [CW-1:0]                 cnt;
    logic                          is_full;
    logic                          is_empty;
    logic [AW-1:0]                 base_addr;
    logic [AW-1:0]                 push_addr;
    logic [AW-1:0]                 top_addr;
    logic                          push_ok;
    logic                          read_ok;
    logic                          pop_ok;
    logic [msm_pkg::STATUS_W-1:0]  status_next;
    logic [msm_pkg::DATA_W-1:0]    ram_rdata;

    // one request in flight; the response register is free when stage b lands
    assign req.ready = !b_valid_reg && (!out_valid_reg || rsp.ready);
    assign req_acc   = req.valid && req.ready;

    assign sel_ok   = {1'b0, req.stack_select} < (msm_pkg::SEL_W + 1)'(STACK_COUNT);
    assign sel_idx  = req.stack_select[SW-1:0];
    assign cnt      = counts_reg[sel_idx];
    assign is_full  = cnt >= CW'(SEG);
    assign is_empty = cnt == '0;

    // segment base is a multiply by a constant; stays below CAPACITY for valid stacks
    assign base_addr = AW'(int'(sel_idx) * SEG);
    assign push_addr = base_addr + AW'(cnt);
    assign top_addr  = base_addr + AW'(cnt - CW'(1));

    // decode the request against the selected stack
    always_comb
    begin
        push_ok     = 1'b0;
        read_ok     = 1'b0;
        pop_ok      = 1'b0;
        status_next = msm_pkg::ST_OK;
        if (!sel_ok)
        begin
            status_next = msm_pkg::ST_BAD;
        end
        else
        begin
            unique case (req.req_type) inside
                msm_pkg::REQ_PUSH:
                begin
                    if (is_full)
                    begin
                        status_next = msm_pkg::ST_FULL;
                    end
                    else
                    begin
                        push_ok = 1'b1;
                    end
                end
                msm_pkg::REQ_POP, msm_pkg::REQ_PEEK:
                begin
                    if (is_empty)
                    begin
                        status_next = msm_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        read_ok = 1'b1;
                        pop_ok  = req.req_type == msm_pkg::REQ_POP;
                    end
                end
                default:
                begin
                    // no operation: report the stack as it stands
                    status_next = msm_pkg::ST_OK;
                end
            endcase
        end
    end

    always_comb
    begin
        cnt_next = cnt;
        if (push_ok)
        begin
            cnt_next = cnt + CW'(1);
        end
        else if (pop_ok)
        begin
            cnt_next = cnt - CW'(1);
        end
    end

    // entry store; a read issued in the cycle after a write sees the written word
    msm_ram #(
        .WIDTH (msm_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (req_acc && push_ok),
        .wr_addr (push_addr),
        .wr_data (req.push_value),
        .rd_en   (req_acc && read_ok),
        .rd_addr (top_addr),
        .rd_data (ram_rdata)
    );

    // counts and control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NC; i++)
            begin
                counts_reg[i] <= '0;
            end
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_acc && sel_ok)
            begin
                counts_reg[sel_idx] <= cnt_next;
            end
            b_valid_reg <= req_acc;
            if (b_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload of stage b and the response register
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            b_status_reg  <= status_next;
            b_rd_take_reg <= read_ok;
            b_empty_reg   <= sel_ok && (cnt_next == '0);
            b_full_reg    <= sel_ok && (cnt_next >= CW'(SEG));
        end
        if (b_valid_reg)
        begin
            out_status_reg <= b_status_reg;
            out_value_reg  <= b_rd_take_reg ? ram_rdata : '0;
            out_empty_reg  <= b_empty_reg;
            out_full_reg   <= b_full_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.read_value = out_value_reg;
    assign rsp.now_empty  = out_empty_reg;
    assign rsp.now_full   = out_full_reg;

    // stage b always lands in the response register in the next cycle
    a_b_lands: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |=> out_valid_reg)
        else $error("stage b result not moved to response register");

    // an accepted request occupies stage b in the next cycle
    a_acc_to_b: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> b_valid_reg && !req.ready)
        else $error("accepted request not held in stage b");

    // a bad stack number never reports data or flags
    a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg == msm_pkg::ST_BAD
            |-> !out_empty_reg && !out_full_reg && out_value_reg == '0)
        else $error("bad stack response carries data or flags");

    // a successful push leaves the stack non-empty
    a_push_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && push_ok |=> !b_empty_reg)
        else $error("stack empty after a successful push");

    // a stalled response holds until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.read_value))
        else $error("response changed while stalled");

endmodule
